// ===== hdl/rtcpsr_pkg.sv =====
// Shared types and constants for the RTCP sender report generator.
// No dependencies; imported by every module of the block.
`default_nettype none

package rtcpsr_pkg;

  // field widths
  localparam int unsigned PacketBytesW = 16;
  localparam int unsigned WordW        = 32;
  localparam int unsigned MsW          = 48;
  localparam int unsigned WallW        = MsW - 1;
  localparam int unsigned CountW       = 64;
  localparam int unsigned IntervalW    = 16;
  localparam int unsigned CfgIndexW    = 8;

  // defaults and fixed values
  localparam int unsigned DefaultHeaderBytes = 12;
  localparam int unsigned DefaultQueueDepth  = 2;
  localparam logic [IntervalW-1:0] ResetIntervalMs = 16'd1000;
  localparam logic [WordW-1:0]     NtpEpochOffset  = 32'd2208988800;

  // wall time split at bit 32: 2^32 = Two32Quo * 1000 + Two32Rem
  localparam int unsigned WallHiW   = WallW - WordW;
  localparam int unsigned Two32QuoW = 23;
  localparam logic [Two32QuoW-1:0] Two32Quo = 23'd4294967;
  localparam int unsigned Two32RemW = 9;
  localparam logic [Two32RemW-1:0] Two32Rem = 9'd296;
  localparam int unsigned SplitW    = WordW + 1;

  // floor(x / 1000) = ((x >> 3) * ceil(2^37 / 125)) >> 37 for x below 2^33
  localparam int unsigned SplitShift = 3;
  localparam int unsigned ScaledW    = SplitW - SplitShift;
  localparam int unsigned RecipW     = 31;
  localparam logic [RecipW-1:0] Recip125 = 31'd1099511628;
  localparam int unsigned RecipShift = 37;
  localparam int unsigned QuoLoW     = 24;

  // ms remainder to fraction: (r * ceil(2^49 / 1000)) >> 17 for r below 1000
  localparam int unsigned RemW      = 10;
  localparam logic [RemW-1:0] MsPerS = 10'd1000;
  localparam int unsigned FracKW    = 40;
  localparam logic [FracKW-1:0] FracK = 40'd562949953422;
  localparam int unsigned FracShift = 17;

  // configuration register indexes
  typedef enum logic [CfgIndexW-1:0] {
    CfgSenderSsrc    = 8'd0,
    CfgReportInterval = 8'd1
  } cfg_reg_e;

  // one due report handed from the front to the back
  typedef struct packed {
    logic [WordW-1:0] ssrc;
    logic [WallW-1:0] wall;
    logic [WordW-1:0] rtp_ts;
    logic [WordW-1:0] packets;
    logic [WordW-1:0] octets;
  } report_entry_t;

endpackage

`default_nettype wire

// ===== hdl/rtcp_sender_report_generator_core.sv =====
// RTCP sender report generator, top level.
// Uses rtcpsr_pkg, rtcpsr_front, rtcpsr_fifo and rtcpsr_ntp.
//
// Usage: one input word per RTP packet sent (size, RTP timestamp, monotonic
// ms, wall-clock ms). Each word updates the 64-bit packet, byte and header
// byte counters. When no report was sent yet, or the report interval has
// elapsed, a sender report word (SSRC, NTP seconds/fraction, RTP timestamp,
// packet and octet counts) comes out on the output channel; otherwise the
// word produces no output. Config writes: index 0 sender SSRC, index 1
// report interval in ms; other indexes are ignored. cfg_ready_o is always high.
// Throughput: one input word per cycle while no report is due. Each report
// passes through the NTP unit in order (pop and split, reciprocal quotient,
// remainder and seconds, output load), and the unit pops no new report until
// the last one is loaded; a two-entry queue absorbs bursts.
// Reset: counters and last report time clear, SSRC 0, interval 1000 ms.
// A stalled receiver holds the output register; the NTP unit and queue then
// fill and in_ready_o drops only when a new report finds no room.
`default_nettype none

module rtcp_sender_report_generator_core #(
  parameter int unsigned HeaderBytes = rtcpsr_pkg::DefaultHeaderBytes,
  parameter int unsigned QueueDepth  = rtcpsr_pkg::DefaultQueueDepth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [rtcpsr_pkg::CfgIndexW-1:0]    cfg_index_i,
  input  logic [rtcpsr_pkg::WordW-1:0]        cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [rtcpsr_pkg::PacketBytesW-1:0] packet_bytes_i,
  input  logic [rtcpsr_pkg::WordW-1:0]        rtp_timestamp_i,
  input  logic [rtcpsr_pkg::MsW-1:0]          now_ms_i,
  input  logic signed [rtcpsr_pkg::MsW-1:0]   wall_ms_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [rtcpsr_pkg::WordW-1:0]        report_ssrc_o,
  output logic [rtcpsr_pkg::WordW-1:0]        ntp_sec_o,
  output logic [rtcpsr_pkg::WordW-1:0]        ntp_frac_o,
  output logic [rtcpsr_pkg::WordW-1:0]        report_rtp_timestamp_o,
  output logic [rtcpsr_pkg::WordW-1:0]        sent_packets_o,
  output logic [rtcpsr_pkg::WordW-1:0]        sent_octets_o
);
  import rtcpsr_pkg::*;

  logic          push_valid;
  logic          push_ready;
  report_entry_t push_entry;
  logic          pop_valid;
  logic          pop_ready;
  report_entry_t pop_entry;

  // counters and report decision
  rtcpsr_front #(
    .HeaderBytes(HeaderBytes)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .packet_bytes_i (packet_bytes_i),
    .rtp_timestamp_i(rtp_timestamp_i),
    .now_ms_i       (now_ms_i),
    .wall_ms_i      (wall_ms_i),
    .push_valid_o   (push_valid),
    .push_ready_i   (push_ready),
    .push_entry_o   (push_entry)
  );

  // due reports waiting for the NTP unit
  rtcpsr_fifo #(
    .QueueDepth(QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_entry_i(push_entry),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_entry_o (pop_entry)
  );

  // NTP conversion and output register
  rtcpsr_ntp u_ntp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .pop_valid_i           (pop_valid),
    .pop_ready_o           (pop_ready),
    .pop_entry_i           (pop_entry),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .report_ssrc_o         (report_ssrc_o),
    .ntp_sec_o             (ntp_sec_o),
    .ntp_frac_o            (ntp_frac_o),
    .report_rtp_timestamp_o(report_rtp_timestamp_o),
    .sent_packets_o        (sent_packets_o),
    .sent_octets_o         (sent_octets_o)
  );

endmodule

`default_nettype wire

// ===== hdl/rtcpsr_front.sv =====
// Front end: config registers, running counters and report-due decision.
// Depends on rtcpsr_pkg; pushes due reports into rtcpsr_fifo.
`default_nettype none

module rtcpsr_front #(
  parameter int unsigned HeaderBytes = rtcpsr_pkg::DefaultHeaderBytes
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [rtcpsr_pkg::CfgIndexW-1:0]        cfg_index_i,
  input  logic [rtcpsr_pkg::WordW-1:0]            cfg_data_i,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic [rtcpsr_pkg::PacketBytesW-1:0]     packet_bytes_i,
  input  logic [rtcpsr_pkg::WordW-1:0]            rtp_timestamp_i,
  input  logic [rtcpsr_pkg::MsW-1:0]              now_ms_i,
  input  logic signed [rtcpsr_pkg::MsW-1:0]       wall_ms_i,
  output logic                                    push_valid_o,
  input  logic                                    push_ready_i,
  output rtcpsr_pkg::report_entry_t               push_entry_o
);
  import rtcpsr_pkg::*;

  logic [WordW-1:0]     ssrc_q, ssrc_d;
  logic [IntervalW-1:0] interval_q, interval_d;
  logic [CountW-1:0]    packets_q, packets_d;
  logic [CountW-1:0]    bytes_q, bytes_d;
  logic [CountW-1:0]    hdr_q, hdr_d;
  logic [MsW-1:0]       last_q, last_d;
  logic                 s1_valid_q, s1_valid_d;
  logic [WordW-1:0]     s1_ts_q;
  logic [MsW-1:0]       s1_now_q;
  logic [WallW-1:0]     s1_wall_q;

  logic                 in_fire;
  logic                 s1_fire;
  logic                 due;
  logic [MsW:0]         elapsed;
  logic [CountW:0]      net_bytes;

  assign cfg_ready_o = 1'b1;

  // report due: never reported, or interval passed without time going back
  assign elapsed = {1'b0, s1_now_q} - {1'b0, last_q};
  assign due = (last_q == '0) ||
               (!elapsed[MsW] && (elapsed[MsW-1:0] >= MsW'(interval_q)));

  // octets net of header bytes, unless that would go below zero
  assign net_bytes = {1'b0, bytes_q} - {1'b0, hdr_q};

  // stage hands off when no report is due or the queue takes it
  assign s1_fire    = s1_valid_q && (!due || push_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  assign push_valid_o         = s1_valid_q && due;
  assign push_entry_o.ssrc    = ssrc_q;
  assign push_entry_o.wall    = s1_wall_q;
  assign push_entry_o.rtp_ts  = s1_ts_q;
  assign push_entry_o.packets = packets_q[WordW-1:0];
  assign push_entry_o.octets  = net_bytes[CountW] ? bytes_q[WordW-1:0]
                                                  : net_bytes[WordW-1:0];

  // config writes
  always_comb begin
    ssrc_d     = ssrc_q;
    interval_d = interval_q;
    if (cfg_valid_i) begin
      if (cfg_index_i == CfgSenderSsrc) begin
        ssrc_d = cfg_data_i;
      end
      if (cfg_index_i == CfgReportInterval) begin
        interval_d = cfg_data_i[IntervalW-1:0];
      end
    end
  end

  // counters advance on every accepted word
  always_comb begin
    packets_d  = packets_q;
    bytes_d    = bytes_q;
    hdr_d      = hdr_q;
    last_d     = last_q;
    s1_valid_d = s1_valid_q;
    if (s1_fire) begin
      s1_valid_d = 1'b0;
      if (due) begin
        last_d = s1_now_q;
      end
    end
    if (in_fire) begin
      packets_d  = packets_q + CountW'(1);
      bytes_d    = bytes_q + CountW'(packet_bytes_i);
      hdr_d      = hdr_q + CountW'(HeaderBytes);
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ssrc_q     <= '0;
      interval_q <= ResetIntervalMs;
      packets_q  <= '0;
      bytes_q    <= '0;
      hdr_q      <= '0;
      last_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      ssrc_q     <= ssrc_d;
      interval_q <= interval_d;
      packets_q  <= packets_d;
      bytes_q    <= bytes_d;
      hdr_q      <= hdr_d;
      last_q     <= last_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  // item payload, wall time clamped at zero
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_ts_q   <= rtp_timestamp_i;
      s1_now_q  <= now_ms_i;
      s1_wall_q <= wall_ms_i[MsW-1] ? '0 : wall_ms_i[WallW-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rtcpsr_fifo.sv =====
// Short queue of due reports between the front and the back.
// Depends on rtcpsr_pkg for the entry type.
`default_nettype none

module rtcpsr_fifo #(
  parameter int unsigned QueueDepth = rtcpsr_pkg::DefaultQueueDepth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_valid_i,
  output logic                      push_ready_o,
  input  rtcpsr_pkg::report_entry_t push_entry_i,
  output logic                      pop_valid_o,
  input  logic                      pop_ready_i,
  output rtcpsr_pkg::report_entry_t pop_entry_o
);
  import rtcpsr_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);

  report_entry_t     mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              push_fire;
  logic              pop_fire;

  assign push_ready_o = (count_q != CntW'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_entry_o  = mem_q[rd_ptr_q];
  assign push_fire    = push_valid_i && push_ready_o;
  assign pop_fire     = pop_valid_o && pop_ready_i;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_fire) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_fire) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    unique case ({push_fire, pop_fire})
      2'b10:   count_d = count_q + CntW'(1);
      2'b01:   count_d = count_q - CntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage write
  always_ff @(posedge clk_i) begin
    if (push_fire) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rtcpsr_ntp.sv =====
// Back end: NTP seconds and fraction by reciprocal multiplication over a sequence
// of states, then the output register. Depends on rtcpsr_pkg.
`default_nettype none

module rtcpsr_ntp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          pop_valid_i,
  output logic                          pop_ready_o,
  input  rtcpsr_pkg::report_entry_t     pop_entry_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rtcpsr_pkg::WordW-1:0]  report_ssrc_o,
  output logic [rtcpsr_pkg::WordW-1:0]  ntp_sec_o,
  output logic [rtcpsr_pkg::WordW-1:0]  ntp_frac_o,
  output logic [rtcpsr_pkg::WordW-1:0]  report_rtp_timestamp_o,
  output logic [rtcpsr_pkg::WordW-1:0]  sent_packets_o,
  output logic [rtcpsr_pkg::WordW-1:0]  sent_octets_o
);
  import rtcpsr_pkg::*;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StQuot = 4'b0010,
    StRem  = 4'b0100,
    StHold = 4'b1000
  } ntp_state_e;

  ntp_state_e                   state_q, state_d;
  report_entry_t                entry_q;
  logic [WordW-1:0]             hi_q;
  logic [SplitW-1:0]            split_q;
  logic [QuoLoW-1:0]            quo_lo_q;
  logic [WordW-1:0]             sec_acc_q;
  logic [RemW-1:0]              rem_q;
  logic                         out_valid_q, out_valid_d;
  logic [WordW-1:0]             ssrc_q, sec_q, frac_q, ts_q, pkt_q, oct_q;

  logic [WallHiW-1:0]           wall_hi;
  logic [WordW-1:0]             wall_lo;
  logic [WallHiW+Two32QuoW-1:0] hi_prod;
  logic [WallHiW+Two32RemW-1:0] hi_rem_prod;
  logic [SplitW-1:0]            split_sum;
  logic [ScaledW-1:0]           split_div8;
  logic [ScaledW+RecipW-1:0]    recip_prod;
  logic [2*RemW-1:0]            quo_scaled;
  logic [RemW-1:0]              rem_val;
  logic [RemW+FracKW-1:0]       frac_prod;
  logic                         pop_fire;
  logic                         out_load;

  assign pop_ready_o = (state_q == StIdle);
  assign pop_fire    = pop_valid_i && pop_ready_o;
  assign out_load    = (state_q == StHold) && (!out_valid_q || out_ready_i);

  // wall = hi * 2^32 + lo, so wall / 1000 = hi * Two32Quo + split / 1000
  assign wall_hi     = pop_entry_i.wall[WallW-1:WordW];
  assign wall_lo     = pop_entry_i.wall[WordW-1:0];
  assign hi_prod     = wall_hi * Two32Quo;
  assign hi_rem_prod = wall_hi * Two32Rem;
  assign split_sum   = SplitW'(hi_rem_prod) + SplitW'(wall_lo);

  // quotient of the split part through the reciprocal of 125
  assign split_div8 = split_q[SplitW-1:SplitShift];
  assign recip_prod = split_div8 * Recip125;

  // ms remainder from the low bits only, it stays below 1000
  assign quo_scaled = quo_lo_q[RemW-1:0] * MsPerS;
  assign rem_val    = split_q[RemW-1:0] - quo_scaled[RemW-1:0];

  // fraction of a second scaled to 2^32
  assign frac_prod = rem_q * FracK;

  // sequencer
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        if (pop_fire) begin
          state_d = StQuot;
        end
      end
      StQuot: begin
        state_d = StRem;
      end
      StRem: begin
        state_d = StHold;
      end
      StHold: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // conversion datapath and captured report fields
  always_ff @(posedge clk_i) begin
    if (pop_fire) begin
      entry_q <= pop_entry_i;
      hi_q    <= hi_prod[WordW-1:0];
      split_q <= split_sum;
    end
    if (state_q == StQuot) begin
      quo_lo_q <= recip_prod[RecipShift+QuoLoW-1:RecipShift];
    end
    if (state_q == StRem) begin
      rem_q     <= rem_val;
      sec_acc_q <= hi_q + WordW'(quo_lo_q) + NtpEpochOffset;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      ssrc_q <= entry_q.ssrc;
      sec_q  <= sec_acc_q;
      frac_q <= frac_prod[FracShift+WordW-1:FracShift];
      ts_q   <= entry_q.rtp_ts;
      pkt_q  <= entry_q.packets;
      oct_q  <= entry_q.octets;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign report_ssrc_o          = ssrc_q;
  assign ntp_sec_o              = sec_q;
  assign ntp_frac_o             = frac_q;
  assign report_rtp_timestamp_o = ts_q;
  assign sent_packets_o         = pkt_q;
  assign sent_octets_o          = oct_q;

endmodule

`default_nettype wire

// ===== verif/tb_rtcp_sender_report_generator_core.sv =====
// Testbench for rtcp_sender_report_generator_core: a cycle-free predictor of the
// packet/byte counters and report timing checks every sender report word.
// Depends on rtcpsr_pkg and the core RTL only.
`default_nettype none

module tb_rtcp_sender_report_generator_core;
  import rtcpsr_pkg::*;

  // one expected sender report word
  typedef struct packed {
    logic [WordW-1:0] ssrc;
    logic [WordW-1:0] secs;
    logic [WordW-1:0] frac;
    logic [WordW-1:0] rtp_ts;
    logic [WordW-1:0] packets;
    logic [WordW-1:0] octets;
  } sr_word_t;

  localparam int unsigned HdrBytes    = DefaultHeaderBytes;
  localparam longint unsigned MsPerSec = 1000;
  localparam int unsigned DrainCycles = 24;
  localparam int unsigned MaxShown    = 10;
  localparam logic [CfgIndexW-1:0] CfgIdxUnused = 8'hff;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CfgIndexW-1:0]    cfg_index_i;
  logic [WordW-1:0]        cfg_data_i;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic [PacketBytesW-1:0] packet_bytes_i;
  logic [WordW-1:0]        rtp_timestamp_i;
  logic [MsW-1:0]          now_ms_i;
  logic signed [MsW-1:0]   wall_ms_i;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic [WordW-1:0]        report_ssrc_o;
  logic [WordW-1:0]        ntp_sec_o;
  logic [WordW-1:0]        ntp_frac_o;
  logic [WordW-1:0]        report_rtp_timestamp_o;
  logic [WordW-1:0]        sent_packets_o;
  logic [WordW-1:0]        sent_octets_o;

  // predictor state and configuration copy
  logic [CountW-1:0]    sr_packets;
  logic [CountW-1:0]    sr_bytes;
  logic [MsW-1:0]       sr_last_ms;
  logic [WordW-1:0]     sr_ssrc;
  logic [IntervalW-1:0] sr_interval;

  sr_word_t    due_reports[$];
  int          exp_rd = 0;
  int unsigned fail_count = 0;
  int unsigned burst_left;
  bit          valid_held;
  bit          tx_gaps_off;
  int unsigned rx_hold_len;
  int unsigned rx_hold_req;
  int unsigned rx_hold_seen = 0;
  int unsigned rx_hold_left = 0;
  int unsigned rx_mode = 0;
  int unsigned rx_left = 0;
  logic [MsW-1:0]        clock_ms;
  logic signed [MsW-1:0] wall_clock;

  rtcp_sender_report_generator_core DUT (.*);

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #2000000;
    $display("FAIL rtcp_sender_report_generator_core");
    $finish;
  end

  // count a packet and work out the report it triggers, if any
  function automatic bit predict_report(input logic [PacketBytesW-1:0] bytes,
                                        input logic [WordW-1:0] ts,
                                        input logic [MsW-1:0] now,
                                        input logic signed [MsW-1:0] wall,
                                        output sr_word_t rep);
    logic [CountW-1:0] hdr;
    logic [CountW-1:0] wall_pos;
    sr_packets = sr_packets + CountW'(1);
    sr_bytes   = sr_bytes + CountW'(bytes);
    if (sr_last_ms != '0) begin
      if (now < sr_last_ms) return 1'b0;
      if ((now - sr_last_ms) < MsW'(sr_interval)) return 1'b0;
    end
    sr_last_ms = now;
    hdr = sr_packets * CountW'(HdrBytes);
    // negative wall time counts as zero
    wall_pos = wall[MsW-1] ? '0 : CountW'(wall);
    rep.ssrc    = sr_ssrc;
    rep.secs    = WordW'(wall_pos / MsPerSec) + NtpEpochOffset;
    rep.frac    = WordW'(((wall_pos % MsPerSec) << 32) / MsPerSec);
    rep.rtp_ts  = ts;
    rep.packets = sr_packets[WordW-1:0];
    rep.octets  = (sr_bytes >= hdr) ? WordW'(sr_bytes - hdr) : sr_bytes[WordW-1:0];
    return 1'b1;
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= MaxShown) $display("mismatch: %s", msg);
  endfunction

  function automatic void check_field(input string name, input logic [WordW-1:0] want,
                                      input logic [WordW-1:0] got);
    if (got !== want)
      note_failure($sformatf("%s expected %h got %h", name, want, got));
  endfunction

  // report word check
  always @(posedge clk_i) begin : report_check
    sr_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (exp_rd >= due_reports.size()) begin
        note_failure("report word with none expected");
      end else begin
        want = due_reports[exp_rd];
        exp_rd++;
        check_field("report_ssrc", want.ssrc, report_ssrc_o);
        check_field("ntp_sec", want.secs, ntp_sec_o);
        check_field("ntp_frac", want.frac, ntp_frac_o);
        check_field("report_rtp_timestamp", want.rtp_ts, report_rtp_timestamp_o);
        check_field("sent_packets", want.packets, sent_packets_o);
        check_field("sent_octets", want.octets, sent_octets_o);
      end
    end
  end

  // receiver: long hold on request, else runs of always-ready, light and heavy stalls
  always @(posedge clk_i) begin
    if (rx_hold_req != rx_hold_seen) begin
      rx_hold_seen = rx_hold_req;
      rx_hold_left = rx_hold_len;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_left = $urandom_range(8, 64);
      end
      rx_left--;
      case (rx_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom_range(0, 3) != 0);
        default: out_ready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic drop_in_valid();
    if (valid_held) begin
      in_valid_i <= 1'b0;
      valid_held = 1'b0;
    end
  endtask

  // offer one packet word in bursts with random gaps, predict on acceptance
  task automatic send_packet(input logic [PacketBytesW-1:0] bytes, input logic [WordW-1:0] ts,
                             input logic [MsW-1:0] now, input logic signed [MsW-1:0] wall);
    int unsigned gap;
    sr_word_t rep;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (tx_gaps_off || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        drop_in_valid();
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i      <= 1'b1;
    packet_bytes_i  <= bytes;
    rtp_timestamp_i <= ts;
    now_ms_i        <= now;
    wall_ms_i       <= wall;
    valid_held = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    if (predict_report(bytes, ts, now, wall, rep)) due_reports = {due_reports, rep};
  endtask

  // sender pause until every report is out, then let the pipeline settle
  task automatic wait_drain();
    drop_in_valid();
    while (exp_rd != due_reports.size()) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CfgIndexW-1:0] idx, input logic [WordW-1:0] data);
    wait_drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgSenderSsrc:     sr_ssrc = data;
      CfgReportInterval: sr_interval = data[IntervalW-1:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  // reset defaults: first report at time zero, clamping, backwards time, interval edge
  task automatic test_first_reports();
    send_packet(16'd0, 32'd0, 48'd0, -48'sd1);
    send_packet(16'hffff, 32'hffff_ffff, 48'd0, 48'sd999);
    send_packet(16'd1, 32'h1234_5678, 48'd500, 48'sh7fff_ffff_ffff);
    send_packet(16'd11, 32'd0, 48'd400, 48'sd0);
    send_packet(16'd12, 32'hdead_beef, 48'd1499, 48'sd1000);
    send_packet(16'd13, 32'h0f0f_0f0f, 48'd1500, 48'sh8000_0000_0000);
    send_packet(16'd100, 32'hf0f0_f0f0, 48'd2499, 48'sd1000);
  endtask

  // register writes: masking of the interval, zero interval, unknown index, extremes
  task automatic test_config_writes();
    write_register(CfgSenderSsrc, 32'hffff_ffff);
    write_register(CfgReportInterval, 32'hffff_0000);
    write_register(CfgIdxUnused, 32'h0000_0005);
    send_packet(16'd40, 32'h1111_1111, 48'd2499, 48'sd1_700_000_000_123);
    send_packet(16'd41, 32'h2222_2222, 48'd2499, 48'sd1_700_000_000_456);
    send_packet(16'd42, 32'h3333_3333, 48'd2498, 48'sd1_700_000_000_789);
    write_register(CfgReportInterval, 32'h0000_0001);
    send_packet(16'd1500, 32'h4444_4444, 48'd2500, 48'sd1_700_000_001_000);
    send_packet(16'd1500, 32'h5555_5555, 48'd2500, 48'sd1_700_000_001_001);
    write_register(CfgSenderSsrc, 32'h0);
    write_register(CfgReportInterval, 32'h1234_ffff);
    send_packet(16'd1200, 32'h6666_6666, 48'd2500 + 48'd65534, 48'sd5);
    send_packet(16'd1200, 32'h7777_7777, 48'd2500 + 48'd65535, 48'sd1);
    clock_ms = 48'd2500 + 48'd65535;
  endtask

  // random packet stream on a given interval
  task automatic test_random_traffic(input int unsigned count, input logic [IntervalW-1:0] ivl);
    logic [MsW-1:0]          now;
    logic signed [MsW-1:0]   wall;
    logic [PacketBytesW-1:0] bytes;
    write_register(CfgSenderSsrc, $urandom());
    write_register(CfgReportInterval, {16'($urandom()), ivl});
    for (int unsigned i = 0; i < count; i++) begin
      // mostly forward time, now and then a step back
      if ($urandom_range(0, 15) == 0 && clock_ms > 48'd5000) begin
        now = clock_ms - MsW'($urandom_range(1, 5000));
      end else begin
        clock_ms = clock_ms + MsW'($urandom_range(0, 2 * int'(ivl) + 2));
        now = clock_ms;
      end
      case ($urandom_range(0, 7))
        0: wall = MsW'({$urandom(), $urandom()});
        1: wall = -MsW'($urandom_range(1, 32'h7fff_ffff));
        default: begin
          wall_clock = wall_clock + MsW'($urandom_range(0, 2000));
          wall = wall_clock;
        end
      endcase
      bytes = ($urandom_range(0, 3) == 0) ? PacketBytesW'($urandom_range(0, 24))
                                          : PacketBytesW'($urandom_range(1, 65535));
      send_packet(bytes, $urandom(), now, wall);
    end
  endtask

  // receiver holds off long while the sender keeps offering reports
  task automatic test_backpressure();
    write_register(CfgReportInterval, 32'h0);
    rx_hold_len = 400;
    rx_hold_req++;
    tx_gaps_off = 1'b1;
    for (int unsigned i = 0; i < 40; i++) begin
      clock_ms = clock_ms + MsW'($urandom_range(0, 3));
      send_packet(PacketBytesW'($urandom_range(1, 65535)), $urandom(), clock_ms,
                  MsW'({$urandom(), $urandom()}));
    end
    tx_gaps_off = 1'b0;
    wait_drain();
  endtask

  // top bits of the monotonic time, then stale times that report nothing
  task automatic test_time_extremes();
    write_register(CfgReportInterval, 32'h1);
    send_packet(16'd64, $urandom(), 48'h5555_5555_5555, 48'sh7fff_ffff_ffff);
    send_packet(16'd64, $urandom(), 48'haaaa_aaaa_aaaa, 48'sh8000_0000_0000);
    send_packet(16'd64, $urandom(), 48'hffff_ffff_fffe, 48'sd0);
    send_packet(16'd64, $urandom(), 48'hffff_ffff_ffff, 48'sd999);
    for (int unsigned i = 0; i < 6; i++)
      send_packet(PacketBytesW'($urandom()), $urandom(), MsW'({$urandom(), $urandom()}),
                  MsW'({$urandom(), $urandom()}));
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = '0;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    packet_bytes_i  = '0;
    rtp_timestamp_i = '0;
    now_ms_i        = '0;
    wall_ms_i       = '0;
    sr_packets  = '0;
    sr_bytes    = '0;
    sr_last_ms  = '0;
    sr_ssrc     = '0;
    sr_interval = ResetIntervalMs;
    burst_left  = 0;
    valid_held  = 1'b0;
    tx_gaps_off = 1'b0;
    rx_hold_len = 0;
    rx_hold_req = 0;
    clock_ms    = '0;
    wall_clock  = 48'sd1_700_000_000_000;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_first_reports();
    test_config_writes();
    test_random_traffic(100, 16'd1);
    test_random_traffic(50, 16'd0);
    test_random_traffic(100, 16'd1000);
    test_random_traffic(100, IntervalW'($urandom_range(2, 65534)));
    test_random_traffic(40, 16'hffff);
    test_backpressure();
    test_time_extremes();
    wait_drain();

    if (fail_count == 0 && due_reports.size() == exp_rd) begin
      $display("PASS rtcp_sender_report_generator_core");
    end else begin
      $display("FAIL rtcp_sender_report_generator_core");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/rtcpsr_pkg.sv
hdl/rtcpsr_front.sv
hdl/rtcpsr_fifo.sv
hdl/rtcpsr_ntp.sv
hdl/rtcp_sender_report_generator_core.sv
verif/tb_rtcp_sender_report_generator_core.sv
